FILE: src/bia_pkg.sv
package bia_pkg;

   localparam int ID_SPACE_DEF = 32768;
   localparam int CFG_W        = 15;
   localparam int PREV_W       = 16;
   localparam int OP_W         = 2;
   localparam int STATUS_W     = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int WORD_BITS    = 32;
   localparam int BIT_W        = 5;

   localparam logic [CFG_W-1:0] SYSTEM_LOW_RST  = 15'd400;
   localparam logic [CFG_W-1:0] SYSTEM_HIGH_RST = 15'd999;
   localparam logic [CFG_W-1:0] NORMAL_LOW_RST  = 15'd1000;
   localparam logic [CFG_W-1:0] NORMAL_HIGH_RST = 15'd29999;

   typedef enum logic [OP_W-1:0] {
      OP_MARK   = 2'd0,
      OP_SYSTEM = 2'd1,
      OP_NORMAL = 2'd2,
      OP_GROUP  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_FRESH     = 2'd0,
      ST_REVIVED   = 2'd1,
      ST_EXHAUSTED = 2'd2,
      ST_MARKED    = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SYSTEM_LOW  = 2'd0,
      REG_SYSTEM_HIGH = 2'd1,
      REG_NORMAL_LOW  = 2'd2,
      REG_NORMAL_HIGH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] rsv;
      logic [WORD_BITS-1:0] used;
   } map_word_type;

   typedef struct packed {
      logic clr_wr;
      logic capture;
      logic look_rd;
      logic decide;
      logic scan_rd;
      logic scan_eval;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic decide_done;
      logic scan_done;
   } sts_type;

endpackage

FILE: src/bitmap_id_allocator_top.sv
// Account ID allocator over a used/reserved bitmap held in one single-port memory of
// 32-ID words (ID_SPACE/32 words, 1024 by default). After reset the block sweeps the
// memory clear, one word per cycle, and takes no request until the sweep ends;
// configuration writes are taken throughout. A request is then handled one at a time:
// it is captured and the word holding its previous ID is read, then it is decided; a mark,
// a revival or an empty range is then loaded into the response register once that is free.
// A scan adds, before that load, a memory read, then an evaluate and write back, for every
// 32-ID word it visits, up to the number of words the range covers. A new request is
// accepted while the previous response still waits in the output register.
module bitmap_id_allocator_top #(
   parameter int ID_SPACE = bia_pkg::ID_SPACE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bia_pkg::OP_W-1:0]       req_op,
   input  logic [bia_pkg::PREV_W-1:0]     req_previous_id,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bia_pkg::CFG_W-1:0]      rsp_assigned_id,
   output logic [bia_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                           csr_we,
   input  logic [bia_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bia_pkg::CFG_W-1:0]      csr_wdata
);

   bia_pkg::cmd_type cmd;
   bia_pkg::sts_type sts;

   bia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   bia_datapath #(
      .ID_SPACE (ID_SPACE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_op          (req_op),
      .req_previous_id (req_previous_id),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_assigned_id (rsp_assigned_id),
      .rsp_status      (rsp_status)
   );

   a_no_request_while_clearing : assert property (@(posedge clock) disable iff (reset)
      cmd.clr_wr |-> !req_ready)
      else $error("request port open during map clear");

   a_load_into_free_slot : assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("response loaded over a pending response");

   a_zero_id_without_grant : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == bia_pkg::ST_EXHAUSTED || rsp_status == bia_pkg::ST_MARKED))
      |-> (rsp_assigned_id == '0))
      else $error("nonzero id on exhausted or mark response");

   a_response_follows_load : assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("response not presented after load");

endmodule

FILE: src/bia_ctrl.sv
module bia_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bia_pkg::cmd_type cmd,
   input  bia_pkg::sts_type sts
);

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_LOOK   = 7'b0000100,
      S_DECIDE = 7'b0001000,
      S_SREAD  = 7'b0010000,
      S_SEVAL  = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.look_rd = 1'b1;
            state_in    = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = sts.decide_done ? S_FINISH : S_SREAD;
         end
         S_SREAD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_SEVAL;
         end
         S_SEVAL: begin
            cmd.scan_eval = 1'b1;
            state_in      = sts.scan_done ? S_FINISH : S_SREAD;
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/bia_datapath.sv
module bia_datapath #(
   parameter int ID_SPACE = bia_pkg::ID_SPACE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bia_pkg::cmd_type               cmd,
   output bia_pkg::sts_type               sts,
   input  logic [bia_pkg::OP_W-1:0]       req_op,
   input  logic [bia_pkg::PREV_W-1:0]     req_previous_id,
   input  logic                           csr_we,
   input  logic [bia_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bia_pkg::CFG_W-1:0]      csr_wdata,
   output logic [bia_pkg::CFG_W-1:0]      rsp_assigned_id,
   output logic [bia_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int Words  = (ID_SPACE + bia_pkg::WORD_BITS - 1) / bia_pkg::WORD_BITS;
   localparam int WordAw = (Words > 1) ? $clog2(Words) : 1;
   localparam int CW     = bia_pkg::CFG_W;
   localparam int PW     = bia_pkg::PREV_W;
   localparam int WB     = bia_pkg::WORD_BITS;
   localparam int BW     = bia_pkg::BIT_W;
   localparam logic [PW:0]   MapLimit = (PW+1)'(ID_SPACE);
   localparam logic [PW-1:0] LastId   = PW'(ID_SPACE - 1);

   // configuration
   logic [CW-1:0] sys_lo_ff, sys_lo_in, sys_hi_ff, sys_hi_in;
   logic [CW-1:0] norm_lo_ff, norm_lo_in, norm_hi_ff, norm_hi_in;

   // request and scan state
   bia_pkg::op_type     op_ff, op_in;
   logic [PW-1:0]       prev_ff, prev_in;
   logic [WordAw-1:0]   ptr_ff, ptr_in;
   logic [CW-1:0]       res_id_ff, res_id_in;
   bia_pkg::status_type res_status_ff, res_status_in;
   logic [CW-1:0]       rsp_id_ff, rsp_id_in;
   bia_pkg::status_type rsp_status_ff, rsp_status_in;

   // map memory
   bia_pkg::map_word_type map_mem [Words];
   bia_pkg::map_word_type map_q_ff;
   bia_pkg::map_word_type wr_data;
   logic                  wr_en, rd_en;
   logic [WordAw-1:0]     wr_addr, rd_addr;

   logic              is_mark, scan_up, prev_in_map, prev_in_range, used_bit, revive;
   logic              range_empty, scan_last, found;
   logic [CW-1:0]     range_lo, range_hi;
   logic [PW-1:0]     lo_id, hi_clip, found_id;
   logic [WordAw-1:0] prev_word, lo_word, hi_word;
   logic [BW-1:0]     prev_bit, pick_idx;
   logic [WB-1:0]     prev_onehot, word_mask, free_bits, sel, pick, below;
   logic [WB-1:0]     pick_o, below_o, visit;

   assign is_mark     = (op_ff == bia_pkg::OP_MARK);
   assign scan_up     = (op_ff == bia_pkg::OP_NORMAL);
   assign range_lo    = scan_up ? norm_lo_ff : sys_lo_ff;
   assign range_hi    = scan_up ? norm_hi_ff : sys_hi_ff;
   assign lo_id       = PW'(range_lo);
   assign hi_clip     = ((PW+1)'(range_hi) > (PW+1)'(LastId)) ? LastId : PW'(range_hi);
   assign range_empty = lo_id > hi_clip;
   assign lo_word     = WordAw'(lo_id >> BW);
   assign hi_word     = WordAw'(hi_clip >> BW);

   assign prev_in_map   = {1'b0, prev_ff} < MapLimit;
   assign prev_word     = WordAw'(prev_ff >> BW);
   assign prev_bit      = prev_ff[BW-1:0];
   assign prev_onehot   = WB'(1) << prev_bit;
   assign prev_in_range = (prev_ff >= lo_id) && (prev_ff <= PW'(range_hi));
   assign used_bit      = map_q_ff.used[prev_bit];

   always_comb begin
      if (op_ff == bia_pkg::OP_GROUP) begin
         revive = (prev_ff != '0) && prev_in_map && !used_bit;
      end else begin
         revive = prev_in_range && prev_in_map && !used_bit;
      end
   end

   // one word of the scan: in-range bits, first free bit in scan order, bits passed over
   always_comb begin
      for (int b = 0; b < WB; b++) begin
         word_mask[b] = ((ptr_ff != lo_word) || (BW'(b) >= lo_id[BW-1:0])) &&
                        ((ptr_ff != hi_word) || (BW'(b) <= hi_clip[BW-1:0]));
      end
      free_bits = word_mask & ~map_q_ff.used & ~map_q_ff.rsv;
      for (int b = 0; b < WB; b++) begin
         sel[b] = scan_up ? free_bits[b] : free_bits[WB-1-b];
      end
      pick  = sel & (~sel + WB'(1));
      below = pick | (pick - WB'(1));
      for (int b = 0; b < WB; b++) begin
         pick_o[b]  = scan_up ? pick[b]  : pick[WB-1-b];
         below_o[b] = scan_up ? below[b] : below[WB-1-b];
      end
      pick_idx = '0;
      for (int b = 0; b < WB; b++) begin
         pick_idx = pick_idx | (pick_o[b] ? BW'(b) : BW'(0));
      end
   end

   assign found     = |free_bits;
   assign visit     = found ? (word_mask & below_o) : word_mask;
   assign scan_last = scan_up ? (ptr_ff == hi_word) : (ptr_ff == lo_word);
   assign found_id  = (PW'(ptr_ff) << BW) | PW'(pick_idx);

   assign sts.clr_last    = (ptr_ff == WordAw'(Words - 1));
   assign sts.decide_done = is_mark || revive || range_empty;
   assign sts.scan_done   = found || scan_last;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = map_q_ff;
      if (cmd.clr_wr) begin
         wr_en   = 1'b1;
         wr_data = '0;
      end else if (cmd.decide) begin
         wr_addr = prev_word;
         if (is_mark) begin
            wr_en       = prev_in_map;
            wr_data.rsv = map_q_ff.rsv | prev_onehot;
         end else begin
            wr_en        = revive;
            wr_data.used = map_q_ff.used | prev_onehot;
         end
      end else if (cmd.scan_eval) begin
         wr_en        = 1'b1;
         wr_data.used = map_q_ff.used | visit;
      end
   end

   assign rd_en   = cmd.look_rd || cmd.scan_rd;
   assign rd_addr = cmd.look_rd ? prev_word : ptr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         map_q_ff <= map_mem[rd_addr];
      end
   end

   always_comb begin
      sys_lo_in  = sys_lo_ff;
      sys_hi_in  = sys_hi_ff;
      norm_lo_in = norm_lo_ff;
      norm_hi_in = norm_hi_ff;
      if (csr_we) begin
         unique case (bia_pkg::csr_index_type'(csr_index))
            bia_pkg::REG_SYSTEM_LOW:  sys_lo_in  = csr_wdata;
            bia_pkg::REG_SYSTEM_HIGH: sys_hi_in  = csr_wdata;
            bia_pkg::REG_NORMAL_LOW:  norm_lo_in = csr_wdata;
            bia_pkg::REG_NORMAL_HIGH: norm_hi_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      op_in         = op_ff;
      prev_in       = prev_ff;
      ptr_in        = ptr_ff;
      res_id_in     = res_id_ff;
      res_status_in = res_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.capture) begin
         op_in   = bia_pkg::op_type'(req_op);
         prev_in = req_previous_id;
      end
      if (cmd.clr_wr) begin
         ptr_in = ptr_ff + WordAw'(1);
      end else if (cmd.decide) begin
         ptr_in = scan_up ? lo_word : hi_word;
         if (is_mark) begin
            res_id_in     = '0;
            res_status_in = bia_pkg::ST_MARKED;
         end else if (revive) begin
            res_id_in     = prev_ff[CW-1:0];
            res_status_in = bia_pkg::ST_REVIVED;
         end else begin
            res_id_in     = '0;
            res_status_in = bia_pkg::ST_EXHAUSTED;
         end
      end else if (cmd.scan_eval) begin
         ptr_in = scan_up ? (ptr_ff + WordAw'(1)) : (ptr_ff - WordAw'(1));
         if (found) begin
            res_id_in     = found_id[CW-1:0];
            res_status_in = bia_pkg::ST_FRESH;
         end else begin
            res_id_in     = '0;
            res_status_in = bia_pkg::ST_EXHAUSTED;
         end
      end
      if (cmd.load_rsp) begin
         rsp_id_in     = res_id_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sys_lo_ff  <= bia_pkg::SYSTEM_LOW_RST;
         sys_hi_ff  <= bia_pkg::SYSTEM_HIGH_RST;
         norm_lo_ff <= bia_pkg::NORMAL_LOW_RST;
         norm_hi_ff <= bia_pkg::NORMAL_HIGH_RST;
         ptr_ff     <= '0;
      end else begin
         sys_lo_ff  <= sys_lo_in;
         sys_hi_ff  <= sys_hi_in;
         norm_lo_ff <= norm_lo_in;
         norm_hi_ff <= norm_hi_in;
         ptr_ff     <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      prev_ff       <= prev_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_assigned_id = rsp_id_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
